/* src/rbd_pkg.sv */
// Package for the ring buffer deque: opcodes, status codes, back-end actions,
// the command control struct and default sizes. No dependencies.
package rbd_pkg;

  localparam int unsigned DEPTH_DEF       = 64;
  localparam int unsigned DATA_WIDTH_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned OP_W  = 3;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CAP_W = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_AT         = 3'd6,
    OP_CLEAR      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2
  } act_e;

  // Control part of a classified command, passed from front to back.
  typedef struct packed {
    act_e             act;
    status_e          status;
    logic [CAP_W-1:0] count;
    logic             is_empty;
    logic             is_full;
  } ctl_t;

endpackage

/* src/rbd_req_if.sv */
// Request channel of the ring buffer deque: valid/ready plus the request fields.
// Depends on rbd_pkg.
interface rbd_req_if #(
  parameter int unsigned DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic [rbd_pkg::OP_W-1:0]    opcode;
  logic [DATA_WIDTH-1:0]       value;
  logic [rbd_pkg::IDX_W-1:0]   index;

  modport source (output valid, output opcode, output value, output index, input ready);
  modport sink   (input valid, input opcode, input value, input index, output ready);
endinterface

/* src/rbd_rsp_if.sv */
// Response channel of the ring buffer deque: valid/ready plus the result fields.
// Depends on rbd_pkg.
interface rbd_rsp_if #(
  parameter int unsigned DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [DATA_WIDTH-1:0]       data_out;
  logic [rbd_pkg::CAP_W-1:0]   count;
  logic                        is_empty;
  logic                        is_full;

  modport source (output valid, output status, output data_out, output count,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input data_out, input count,
                  input is_empty, input is_full, output ready);
endinterface

/* src/ring_buffer_deque.sv */
// Top level of the ring buffer deque: front end, command queue and back end.
// Depends on rbd_pkg, rbd_req_if, rbd_rsp_if, rbd_front, rbd_queue, rbd_back.

// The ring buffer deque is a double-ended queue of DATA_WIDTH-bit words kept in a
// circular store of DEPTH slots, of which the capacity register selects how many
// are used (zero acts as one, values above DEPTH act as DEPTH). Each request
// carries an opcode (push back, push front, pop front, pop back, peek front,
// peek back, read at a logical index, clear), a value and an index, and yields
// exactly one response with a status, the word read (zero unless a read
// succeeded), the count after the operation and empty and full flags. The block
// accepts one request per clock cycle and returns one response per cycle when
// the response side keeps ready high; the front end updates the head pointer and
// length at the accepting edge, so back-to-back requests see each other's
// effects at once. An accepted request is written into the command queue, and the
// edge that takes it out of the queue also reads the slot store into the response
// register, which drives the response; a response that waits for ready holds the
// later commands in the queue. The command queue lets the request side keep going
// while a response waits; when it fills, request ready drops. Writing the capacity
// empties the deque (head pointer and length go to zero) and must only be done
// while no request is outstanding.
module ring_buffer_deque #(
  parameter int unsigned DEPTH       = rbd_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH  = rbd_pkg::DATA_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = rbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rbd_pkg::CAP_W-1:0] cfg_wdata_i,
  rbd_req_if.sink                   req_i,
  rbd_rsp_if.source                 rsp_o
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CTL_W  = $bits(rbd_pkg::ctl_t);
  localparam int unsigned ENT_W  = CTL_W + ADDR_W + DATA_WIDTH;

  // Classified command as produced by the front end.
  logic                  push;
  rbd_pkg::ctl_t         f_ctl;
  logic [ADDR_W-1:0]     f_addr;
  logic [DATA_WIDTH-1:0] f_data;

  // Command at the head of the queue, as seen by the back end.
  logic                  q_full, q_empty, pop;
  logic [ENT_W-1:0]      q_out;
  rbd_pkg::ctl_t         b_ctl;
  logic [ADDR_W-1:0]     b_addr;
  logic [DATA_WIDTH-1:0] b_data;

  rbd_front #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_ctl_o   (f_ctl),
    .cmd_addr_o  (f_addr),
    .cmd_data_o  (f_data)
  );

  rbd_queue #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_ctl, f_addr, f_data}),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  // Unpack the queue entry in the same field order as it was packed.
  assign b_ctl  = rbd_pkg::ctl_t'(q_out[ENT_W-1 -: CTL_W]);
  assign b_addr = q_out[DATA_WIDTH +: ADDR_W];
  assign b_data = q_out[DATA_WIDTH-1:0];

  rbd_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .ctl_i     (b_ctl),
    .addr_i    (b_addr),
    .data_i    (b_data),
    .rsp       (rsp_o)
  );

endmodule

/* src/rbd_front.sv */
// Front end of the ring buffer deque: holds capacity, head pointer and length,
// classifies each request and emits a slot command. Depends on rbd_pkg, rbd_req_if.
module rbd_front #(
  parameter int unsigned DEPTH      = rbd_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF,
  localparam int unsigned ADDR_W    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rbd_pkg::CAP_W-1:0]  cfg_wdata_i,
  rbd_req_if.sink                    req,
  input  logic                       q_full_i,
  output logic                       push_o,
  output rbd_pkg::ctl_t              cmd_ctl_o,
  output logic [ADDR_W-1:0]          cmd_addr_o,
  output logic [DATA_WIDTH-1:0]      cmd_data_o
);

  localparam int unsigned CAP_W = rbd_pkg::CAP_W;
  localparam int unsigned SUM_W = ((ADDR_W > CAP_W) ? ADDR_W : CAP_W) + 1;

  logic [CAP_W-1:0]  cap_q;
  logic [ADDR_W-1:0] head_q, head_d;
  logic [CAP_W-1:0]  cnt_q, cnt_d;

  logic [CAP_W-1:0]  cap_eff;
  logic              full, empty;
  logic [ADDR_W-1:0] head_dec, head_inc;
  logic [SUM_W-1:0]  inc_sum;
  logic [ADDR_W-1:0] base;
  logic [CAP_W-1:0]  logical;
  logic [SUM_W-1:0]  slot_sum;
  logic              accept;

  assign req.ready = !q_full_i;
  assign accept    = req.valid && !q_full_i;
  assign push_o    = accept;

  // Capacity of zero acts as one, capacity above the store depth acts as the depth.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CAP_W'(1);
    end else if (SUM_W'(cap_q) > SUM_W'(DEPTH)) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign full  = (cnt_q >= cap_eff);
  assign empty = (cnt_q == '0);

  assign head_dec = (head_q == '0) ? ADDR_W'(cap_eff - CAP_W'(1)) : head_q - ADDR_W'(1);
  assign inc_sum  = SUM_W'(head_q) + SUM_W'(1);
  assign head_inc = (inc_sum >= SUM_W'(cap_eff)) ? '0 : ADDR_W'(inc_sum);

  // Classification of the request.
  always_comb begin
    head_d              = head_q;
    cnt_d               = cnt_q;
    base                = head_q;
    logical             = '0;
    cmd_ctl_o.act       = rbd_pkg::ACT_NONE;
    cmd_ctl_o.status    = rbd_pkg::ST_OK;
    case (rbd_pkg::op_e'(req.opcode))
      rbd_pkg::OP_PUSH_BACK: begin
        if (full) begin
          cmd_ctl_o.status = rbd_pkg::ST_FULL;
        end else begin
          cmd_ctl_o.act = rbd_pkg::ACT_WRITE;
          logical       = cnt_q;
          cnt_d         = cnt_q + CAP_W'(1);
        end
      end
      rbd_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          cmd_ctl_o.status = rbd_pkg::ST_FULL;
        end else begin
          cmd_ctl_o.act = rbd_pkg::ACT_WRITE;
          base          = head_dec;
          head_d        = head_dec;
          cnt_d         = cnt_q + CAP_W'(1);
        end
      end
      rbd_pkg::OP_POP_FRONT: begin
        if (empty) begin
          cmd_ctl_o.status = rbd_pkg::ST_EMPTY;
        end else begin
          cmd_ctl_o.act = rbd_pkg::ACT_READ;
          head_d        = head_inc;
          cnt_d         = cnt_q - CAP_W'(1);
        end
      end
      rbd_pkg::OP_POP_BACK: begin
        if (empty) begin
          cmd_ctl_o.status = rbd_pkg::ST_EMPTY;
        end else begin
          cmd_ctl_o.act = rbd_pkg::ACT_READ;
          logical       = cnt_q - CAP_W'(1);
          cnt_d         = cnt_q - CAP_W'(1);
        end
      end
      rbd_pkg::OP_PEEK_FRONT: begin
        if (empty) begin
          cmd_ctl_o.status = rbd_pkg::ST_EMPTY;
        end else begin
          cmd_ctl_o.act = rbd_pkg::ACT_READ;
        end
      end
      rbd_pkg::OP_PEEK_BACK: begin
        if (empty) begin
          cmd_ctl_o.status = rbd_pkg::ST_EMPTY;
        end else begin
          cmd_ctl_o.act = rbd_pkg::ACT_READ;
          logical       = cnt_q - CAP_W'(1);
        end
      end
      rbd_pkg::OP_AT: begin
        if (CAP_W'(req.index) >= cnt_q) begin
          cmd_ctl_o.status = rbd_pkg::ST_RANGE;
        end else begin
          cmd_ctl_o.act = rbd_pkg::ACT_READ;
          logical       = CAP_W'(req.index);
        end
      end
      default: begin
        head_d = '0;
        cnt_d  = '0;
      end
    endcase
    cmd_ctl_o.count    = cnt_d;
    cmd_ctl_o.is_empty = (cnt_d == '0);
    cmd_ctl_o.is_full  = (cnt_d == cap_eff);
  end

  // Physical slot: base plus logical position, wrapped once at the capacity.
  always_comb begin
    slot_sum = SUM_W'(base) + SUM_W'(logical);
    if (slot_sum >= SUM_W'(cap_eff)) begin
      slot_sum = slot_sum - SUM_W'(cap_eff);
    end
  end

  assign cmd_addr_o         = ADDR_W'(slot_sum);
  assign cmd_data_o         = req.value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= rbd_pkg::CAP_RESET;
      head_q <= '0;
      cnt_q  <= '0;
    end else if (cfg_we_i) begin
      cap_q  <= cfg_wdata_i;
      head_q <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* src/rbd_queue.sv */
// Short command queue between the front and back ends of the ring buffer deque.
// Depends on rbd_pkg for its default depth.
module rbd_queue #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = rbd_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

/* src/rbd_back.sv */
// Back end of the ring buffer deque: owns the slot store, carries out writes and
// reads, and holds the response register. Depends on rbd_pkg, rbd_rsp_if.
module rbd_back #(
  parameter int unsigned DEPTH      = rbd_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF,
  localparam int unsigned ADDR_W    = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  output logic                   pop_o,
  input  rbd_pkg::ctl_t          ctl_i,
  input  logic [ADDR_W-1:0]      addr_i,
  input  logic [DATA_WIDTH-1:0]  data_i,
  rbd_rsp_if.source              rsp
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;
  rbd_pkg::ctl_t         ctl_q;
  logic                  valid_q;

  assign pop_o = !q_empty_i && (!valid_q || rsp.ready);

  // Slot store with a registered read port; the read register is the response data.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (ctl_i.act == rbd_pkg::ACT_WRITE) begin
        mem_q[addr_i] <= data_i;
      end
      if (ctl_i.act == rbd_pkg::ACT_READ) begin
        rdata_q <= mem_q[addr_i];
      end else begin
        rdata_q <= '0;
      end
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (rsp.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign rsp.valid    = valid_q;
  assign rsp.status   = ctl_q.status;
  assign rsp.data_out = rdata_q;
  assign rsp.count    = ctl_q.count;
  assign rsp.is_empty = ctl_q.is_empty;
  assign rsp.is_full  = ctl_q.is_full;

endmodule
